// ===== rtl/core/bdpc_pkg.sv =====
// shared types and constants of the button debounce press classifier
package bdpc_pkg;

    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned LimitWidth = 16;
    localparam int unsigned EventWidth = 2;

    localparam logic [LimitWidth-1:0] DebounceLimitReset  = 16'd10;
    localparam logic [LimitWidth-1:0] LongPressLimitReset = 16'd1000;

    typedef enum logic [0:0] {
        REG_DEBOUNCE_LIMIT   = 1'b0,
        REG_LONG_PRESS_LIMIT = 1'b1
    } reg_index_t;

    typedef enum logic [EventWidth-1:0] {
        EVENT_NONE  = 2'd0,
        EVENT_SHORT = 2'd1,
        EVENT_LONG  = 2'd2
    } press_event_t;

    typedef enum logic [4:0] {
        PHASE_IDLE     = 5'b00001,
        PHASE_PRESS_DB = 5'b00010,
        PHASE_HELD     = 5'b00100,
        PHASE_LONG     = 5'b01000,
        PHASE_REL_DB   = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [TimeWidth-1:0]  edge_time;
        logic [TimeWidth-1:0]  press_start_time;
    } tracker_state_t;

    typedef struct packed {
        logic [LimitWidth-1:0] debounce_limit;
        logic [LimitWidth-1:0] long_press_limit;
    } limits_t;

endpackage

// ===== rtl/core/bdpc_step.sv =====
// next-state and event logic for one poll
module bdpc_step (
    input  bdpc_pkg::tracker_state_t                 state_cur,
    input  bdpc_pkg::limits_t                        limits,
    input  logic                                     pin_level,
    input  logic [bdpc_pkg::TimeWidth-1:0]           now_ms,
    output bdpc_pkg::tracker_state_t                 state_new,
    output bdpc_pkg::press_event_t                   event_new
);

    logic                            pressed;
    logic [bdpc_pkg::TimeWidth-1:0]  since_edge;
    logic [bdpc_pkg::TimeWidth-1:0]  since_press;
    logic                            debounce_over;
    logic                            long_over;

    assign pressed       = ~pin_level;
    assign since_edge    = now_ms - state_cur.edge_time;
    assign since_press   = now_ms - state_cur.press_start_time;
    assign debounce_over = since_edge >
        {{(bdpc_pkg::TimeWidth-bdpc_pkg::LimitWidth){1'b0}}, limits.debounce_limit};
    assign long_over     = since_press >
        {{(bdpc_pkg::TimeWidth-bdpc_pkg::LimitWidth){1'b0}}, limits.long_press_limit};

    always_comb
    begin
        state_new = state_cur;
        event_new = bdpc_pkg::EVENT_NONE;
        case (state_cur.phase)
            bdpc_pkg::PHASE_PRESS_DB:
            begin
                if (debounce_over)
                begin
                    state_new.phase            = bdpc_pkg::PHASE_HELD;
                    state_new.press_start_time = now_ms;
                end
                else if (!pressed)
                begin
                    state_new.phase     = bdpc_pkg::PHASE_IDLE;
                    state_new.edge_time = now_ms;
                end
            end
            bdpc_pkg::PHASE_HELD:
            begin
                if (long_over)
                begin
                    state_new.phase = bdpc_pkg::PHASE_LONG;
                end
                else if (!pressed)
                begin
                    state_new.phase     = bdpc_pkg::PHASE_REL_DB;
                    state_new.edge_time = now_ms;
                end
            end
            bdpc_pkg::PHASE_LONG:
            begin
                if (!pressed)
                begin
                    state_new.phase     = bdpc_pkg::PHASE_REL_DB;
                    state_new.edge_time = now_ms;
                end
            end
            bdpc_pkg::PHASE_REL_DB:
            begin
                if (debounce_over)
                begin
                    event_new       = long_over ? bdpc_pkg::EVENT_LONG : bdpc_pkg::EVENT_SHORT;
                    state_new.phase = bdpc_pkg::PHASE_IDLE;
                end
                else if (pressed)
                begin
                    state_new.phase     = long_over ? bdpc_pkg::PHASE_LONG
                                                    : bdpc_pkg::PHASE_HELD;
                    state_new.edge_time = now_ms;
                end
            end
            default:
            begin
                state_new.phase = bdpc_pkg::PHASE_IDLE;
                if (pressed)
                begin
                    state_new.phase     = bdpc_pkg::PHASE_PRESS_DB;
                    state_new.edge_time = now_ms;
                end
            end
        endcase
    end

endmodule

// ===== rtl/core/button_debounce_press_classifier.sv =====
// Button debouncer with short and long press classification. Each input item is one poll
// (active-low pin level and a wrapping 32-bit millisecond timestamp) and gives exactly one
// result item: press_event is 0 while nothing ends, 1 when a short press is released and
// 2 when a long press is released. The tracker state and the result register are updated at
// the edge the item is accepted, and a new item is taken in every cycle in which the result
// register is empty or its item is being taken. The limits are written through wr_en,
// wr_index and wr_data; index 0 is the debounce limit (reset 10), index 1 the long-press
// limit (reset 1000).
module button_debounce_press_classifier (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  pin_level,
    input  logic [bdpc_pkg::TimeWidth-1:0]        now_ms,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bdpc_pkg::EventWidth-1:0]       press_event,
    input  logic                                  wr_en,
    input  logic [0:0]                            wr_index,
    input  logic [bdpc_pkg::LimitWidth-1:0]       wr_data
);

    bdpc_pkg::tracker_state_t  state_reg;
    bdpc_pkg::tracker_state_t  state_next;
    bdpc_pkg::limits_t         limits_reg;
    bdpc_pkg::press_event_t    event_next;
    bdpc_pkg::press_event_t    event_reg;
    logic                      out_valid_reg;
    logic                      accept;

    assign in_ready    = !out_valid_reg || out_ready;
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign press_event = event_reg;

    bdpc_step u_step (
        .state_cur (state_reg),
        .limits    (limits_reg),
        .pin_level (pin_level),
        .now_ms    (now_ms),
        .state_new (state_next),
        .event_new (event_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.debounce_limit   <= bdpc_pkg::DebounceLimitReset;
            limits_reg.long_press_limit <= bdpc_pkg::LongPressLimitReset;
        end
        else if (wr_en)
        begin
            case (wr_index)
                bdpc_pkg::REG_DEBOUNCE_LIMIT:   limits_reg.debounce_limit   <= wr_data;
                bdpc_pkg::REG_LONG_PRESS_LIMIT: limits_reg.long_press_limit <= wr_data;
                default:                        limits_reg                  <= limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase            <= bdpc_pkg::PHASE_IDLE;
            state_reg.edge_time        <= '0;
            state_reg.press_start_time <= '0;
            out_valid_reg              <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            event_reg <= event_next;
        end
    end

endmodule

// ===== rtl/core/bdpc_checker.sv =====
// port-level checks of the button debounce press classifier and their binding
module bdpc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [bdpc_pkg::EventWidth-1:0]  press_event
);

    // every accepted item yields a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item produced no result");

    // an empty result register never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(press_event))
        else $error("stalled result changed");

    // the unused event code never appears
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (press_event == bdpc_pkg::EVENT_NONE
                    || press_event == bdpc_pkg::EVENT_SHORT
                    || press_event == bdpc_pkg::EVENT_LONG))
        else $error("invalid press event code");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .press_event (press_event)
);

// ===== bench/button_debounce_press_classifier_tb.sv =====
// self-checking testbench of the button debounce press classifier
module button_debounce_press_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned MaxReported   = 10;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic                            pin_level = 1'b1;
    logic [bdpc_pkg::TimeWidth-1:0]  now_ms = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [bdpc_pkg::EventWidth-1:0] press_event;
    logic                            wr_en = 1'b0;
    logic [0:0]                      wr_index = bdpc_pkg::REG_DEBOUNCE_LIMIT;
    logic [bdpc_pkg::LimitWidth-1:0] wr_data = '0;

    // tracker copy used for prediction
    bdpc_pkg::phase_t                track_phase = bdpc_pkg::PHASE_IDLE;
    logic [bdpc_pkg::TimeWidth-1:0]  edge_time = '0;
    logic [bdpc_pkg::TimeWidth-1:0]  press_start = '0;
    logic [bdpc_pkg::LimitWidth-1:0] debounce_limit = bdpc_pkg::DebounceLimitReset;
    logic [bdpc_pkg::LimitWidth-1:0] long_press_limit = bdpc_pkg::LongPressLimitReset;

    bdpc_pkg::press_event_t          pending_events[$];
    logic [bdpc_pkg::TimeWidth-1:0]  poll_time = '0;
    int unsigned                     polls_sent = 0;
    int unsigned                     shorts_seen = 0;
    int unsigned                     longs_seen = 0;
    int unsigned                     settings_used = 1;
    int unsigned                     mismatches = 0;
    int unsigned                     quiet_cycles = 0;
    int unsigned                     send_idle_pct = 0;
    int unsigned                     recv_stall_pct = 0;
    int unsigned                     hold_left = 0;

    button_debounce_press_classifier DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pin_level   (pin_level),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .press_event (press_event),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic exceeds(input logic [bdpc_pkg::TimeWidth-1:0] t,
                                     input logic [bdpc_pkg::TimeWidth-1:0] since,
                                     input logic [bdpc_pkg::LimitWidth-1:0] limit);
        logic [bdpc_pkg::TimeWidth-1:0] span;
        span = t - since;
        return span > {{(bdpc_pkg::TimeWidth-bdpc_pkg::LimitWidth){1'b0}}, limit};
    endfunction

    function automatic bdpc_pkg::press_event_t classify_poll(
        input logic pin,
        input logic [bdpc_pkg::TimeWidth-1:0] t);
        bdpc_pkg::press_event_t ev;
        logic                   pressed;
        ev = bdpc_pkg::EVENT_NONE;
        pressed = (pin == 1'b0);
        case (track_phase)
            bdpc_pkg::PHASE_PRESS_DB:
            begin
                if (exceeds(t, edge_time, debounce_limit))
                begin
                    track_phase = bdpc_pkg::PHASE_HELD;
                    press_start = t;
                end
                else if (!pressed)
                begin
                    track_phase = bdpc_pkg::PHASE_IDLE;
                    edge_time = t;
                end
            end
            bdpc_pkg::PHASE_HELD:
            begin
                if (exceeds(t, press_start, long_press_limit))
                    track_phase = bdpc_pkg::PHASE_LONG;
                else if (!pressed)
                begin
                    track_phase = bdpc_pkg::PHASE_REL_DB;
                    edge_time = t;
                end
            end
            bdpc_pkg::PHASE_LONG:
            begin
                if (!pressed)
                begin
                    track_phase = bdpc_pkg::PHASE_REL_DB;
                    edge_time = t;
                end
            end
            bdpc_pkg::PHASE_REL_DB:
            begin
                if (exceeds(t, edge_time, debounce_limit))
                begin
                    ev = exceeds(t, press_start, long_press_limit) ? bdpc_pkg::EVENT_LONG
                                                                   : bdpc_pkg::EVENT_SHORT;
                    track_phase = bdpc_pkg::PHASE_IDLE;
                end
                else if (pressed)
                begin
                    track_phase = exceeds(t, press_start, long_press_limit)
                                  ? bdpc_pkg::PHASE_LONG : bdpc_pkg::PHASE_HELD;
                    edge_time = t;
                end
            end
            default:
            begin
                track_phase = bdpc_pkg::PHASE_IDLE;
                if (pressed)
                begin
                    track_phase = bdpc_pkg::PHASE_PRESS_DB;
                    edge_time = t;
                end
            end
        endcase
        return ev;
    endfunction

    task automatic send_poll(input logic pin, input logic [bdpc_pkg::TimeWidth-1:0] t);
        bdpc_pkg::press_event_t ev;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        pin_level <= pin;
        now_ms    <= t;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        ev = classify_poll(pin, t);
        pending_events.push_back(ev);
        polls_sent++;
        if (ev == bdpc_pkg::EVENT_SHORT)
            shorts_seen++;
        else if (ev == bdpc_pkg::EVENT_LONG)
            longs_seen++;
    endtask

    task automatic poll(input logic pin, input int unsigned step);
        poll_time = poll_time + step;
        send_poll(pin, poll_time);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_events.size() > 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_limits(input logic [bdpc_pkg::LimitWidth-1:0] deb,
                              input logic [bdpc_pkg::LimitWidth-1:0] lng);
        wr_en    <= 1'b1;
        wr_index <= bdpc_pkg::REG_DEBOUNCE_LIMIT;
        wr_data  <= deb;
        @(posedge clk);
        debounce_limit = deb;
        wr_index <= bdpc_pkg::REG_LONG_PRESS_LIMIT;
        wr_data  <= lng;
        @(posedge clk);
        long_press_limit = lng;
        wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic press_cycle();
        int unsigned deb;
        int unsigned lng;
        int unsigned hold;
        int unsigned steps;
        int unsigned i;
        deb = debounce_limit;
        lng = long_press_limit;
        repeat ($urandom_range(0, 3))
        begin
            poll(1'b0, $urandom_range(0, deb));
            poll(1'b1, $urandom_range(0, deb));
        end
        poll(1'b0, $urandom_range(0, deb));
        poll(1'($urandom_range(1)), deb + 1 + $urandom_range(0, 3));
        case ($urandom_range(2))
            0: hold = $urandom_range(0, lng);
            1: hold = lng;
            default: hold = lng + 1 + $urandom_range(0, lng / 2 + 4);
        endcase
        steps = $urandom_range(1, 5);
        for (i = 0; i < steps; i++)
            poll(1'b0, hold / steps + $urandom_range(0, 2));
        poll(1'b1, $urandom_range(0, deb));
        repeat ($urandom_range(0, 3))
        begin
            poll(1'b0, $urandom_range(0, deb));
            poll(1'b1, $urandom_range(0, deb));
        end
        poll(1'($urandom_range(1)), deb + 1 + $urandom_range(0, 3));
        repeat ($urandom_range(0, 3))
            poll(1'b1, $urandom_range(0, 2 * deb + 2));
    endtask

    task automatic noise_polls();
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(3) == 0)
                poll_time = $urandom;
            else
                poll_time = poll_time + $urandom_range(0, 2 * debounce_limit + 2);
            send_poll(1'($urandom_range(1)), poll_time);
        end
    endtask

    task automatic generate_traffic(input int unsigned count);
        int unsigned target;
        target = polls_sent + count;
        poll_time = $urandom;
        while (polls_sent < target)
        begin
            if ($urandom_range(9) == 0)
                noise_polls();
            else
                press_cycle();
        end
    endtask

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_poll(1'b1, 32'd0);
        send_poll(1'b0, 32'd100);
        send_poll(1'b1, 32'd105);
        send_poll(1'b0, 32'd110);
        // debounce expiry wins over a released pin
        send_poll(1'b1, 32'd121);
        send_poll(1'b1, 32'd125);
        send_poll(1'b0, 32'd130);
        send_poll(1'b1, 32'd140);
        send_poll(1'b1, 32'd151);
        send_poll(1'b0, 32'd200);
        send_poll(1'b0, 32'd211);
        // long-press expiry wins over a released pin
        send_poll(1'b1, 32'd1212);
        send_poll(1'b1, 32'd1213);
        send_poll(1'b0, 32'd1215);
        send_poll(1'b1, 32'd1220);
        send_poll(1'b1, 32'd1231);
        // limits reached exactly but not exceeded
        send_poll(1'b0, 32'd2000);
        send_poll(1'b0, 32'd2010);
        send_poll(1'b0, 32'd2011);
        send_poll(1'b1, 32'd3011);
        send_poll(1'b1, 32'd3022);
        // timestamp wrap
        send_poll(1'b0, 32'hFFFF_FFFF);
        send_poll(1'b0, 32'd10);
        send_poll(1'b1, 32'd15);
        send_poll(1'b1, 32'd26);
        drain_results();
    endtask

    task automatic test_no_idling();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        generate_traffic(350);
        drain_results();
    endtask

    task automatic test_zero_limits_sender_idle();
        set_limits('0, '0);
        send_idle_pct  = 77;
        recv_stall_pct = 0;
        generate_traffic(350);
        drain_results();
    endtask

    task automatic test_max_limits_receiver_stall();
        set_limits('1, '1);
        send_idle_pct  = 0;
        recv_stall_pct = 77;
        generate_traffic(350);
        drain_results();
    endtask

    task automatic test_mixed_limits_both_idle();
        set_limits(16'($urandom_range(1, 40)), 16'($urandom_range(50, 400)));
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        generate_traffic(350);
        drain_results();
    endtask

    task automatic test_backpressure();
        set_limits(16'd3, 16'd60);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left = 400;
        generate_traffic(70);
        // sender waits for every outstanding result
        in_valid <= 1'b0;
        while (pending_events.size() > 0)
            @(posedge clk);
        recv_stall_pct = 50;
        generate_traffic(70);
        drain_results();
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic note_mismatch(input string what, input int expd, input int got);
        mismatches++;
        if (mismatches <= MaxReported)
            $display("mismatch (%s) at %0t: expected %0d, got %0d", what, $realtime, expd, got);
    endtask

    always @(posedge clk)
    begin
        bdpc_pkg::press_event_t expd;
        if (rst_n)
        begin
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (out_valid === 1'b1 && out_ready)
            begin
                if (pending_events.size() == 0)
                    note_mismatch("unexpected item", -1, int'(press_event));
                else
                begin
                    expd = pending_events.pop_front();
                    if (press_event !== expd)
                        note_mismatch("press_event", int'(expd), int'(press_event));
                end
            end
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("watchdog: no item moved for %0d cycles", quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_no_idling();
        test_zero_limits_sender_idle();
        test_max_limits_receiver_stall();
        test_mixed_limits_both_idle();
        test_backpressure();
        repeat (5) @(posedge clk);
        $display("covered %0d polls under %0d limit settings, %0d short and %0d long presses",
                 polls_sent, settings_used, shorts_seen, longs_seen);
        $display("idling and stall phases plus a long output hold; %0d mismatches", mismatches);
        if (mismatches == 0 && pending_events.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bdpc_pkg.sv
rtl/core/bdpc_step.sv
rtl/core/button_debounce_press_classifier.sv
rtl/core/bdpc_checker.sv
bench/button_debounce_press_classifier_tb.sv
